// File: design/fifo_queue_with_remove_and_search_unit_assert.svh
// Assertion macros for the queue with remove and search.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef FIFO_QUEUE_WITH_REMOVE_AND_SEARCH_UNIT_ASSERT_SVH
`define FIFO_QUEUE_WITH_REMOVE_AND_SEARCH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FQRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/fqrs_pkg.sv
// Shared types and codes for the queue with remove and search.
// No dependencies.
`timescale 1ns / 1ps

package fqrs_pkg;

    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_SEARCH = 3'd4
    } fqrs_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } fqrs_status_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic cmp;
        logic live;
    } fqrs_cell_ctl_t;

    localparam int unsigned KEY_FIELD_W   = 16;
    localparam int unsigned COUNT_FIELD_W = 5;

endpackage

// File: design/fqrs_cell.sv
// One storage cell of the queue: holds an entry and its compare result.
// Depends on fqrs_pkg for the control struct.
`timescale 1ns / 1ps

module fqrs_cell
    import fqrs_pkg::*;
#(
    parameter int unsigned KEY_WIDTH = 16
) (
    input  logic                 aclk,
    input  fqrs_cell_ctl_t       ctl,
    input  logic [KEY_WIDTH-1:0] key_in,
    input  logic [KEY_WIDTH-1:0] neighbor_value,
    output logic [KEY_WIDTH-1:0] value,
    output logic                 match
);

    logic [KEY_WIDTH-1:0] value_reg;
    logic [KEY_WIDTH-1:0] value_next;
    logic                 match_reg;
    logic                 match_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.load) begin
            value_next = key_in;
        end else if (ctl.shift) begin
            value_next = neighbor_value;
        end
        match_next = match_reg;
        if (ctl.cmp) begin
            match_next = ctl.live && (value_reg == key_in);
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

// File: design/fifo_queue_with_remove_and_search_unit.sv
// Queue of process handles with enqueue, dequeue, peek, remove by key and search.
// Depends on fqrs_pkg, fqrs_cell and the assertion macro header.
//
// Each entry lives in its own cell; all cells compare against the key at once and
// shift toward the head together to close a gap. An item passes through S_IDLE, which
// accepts the transfer, S_CMP, in which every cell registers its compare, and S_EXEC,
// which updates the cells and loads the result register. The last step waits while a
// previous result is still held on the output, and no new transfer is accepted
// until that step completes, so a stalled output holds off the next transfer.
// An enqueue to a full queue is dropped with full status.
`timescale 1ns / 1ps

module fifo_queue_with_remove_and_search_unit
    import fqrs_pkg::*;
#(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // key[15:0]
    input  logic [2:0]  s_tuser,  // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // head_value[15:0], found[16], status[18:17], count[23:19]
);

    `include "fifo_queue_with_remove_and_search_unit_assert.svh"

    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
    localparam int unsigned KW_IN   = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    fqrs_op_t             mode_reg;
    fqrs_op_t             mode_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [15:0]          head_reg;
    logic [15:0]          head_next;
    logic                 found_reg;
    logic                 found_next;
    fqrs_status_t         status_reg;
    fqrs_status_t         status_next;

    logic [KEY_WIDTH-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]     match_vec;
    logic [DEPTH-1:0]     before_vec;
    fqrs_cell_ctl_t       cell_ctl [DEPTH];

    logic exec_go;
    logic full;
    logic empty;
    logic any_match;
    logic [31:0] count_wide;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign any_match = |match_vec;
    assign exec_go   = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [DEPTH-1:0] LOW_MASK = (DEPTH'(1) << i) - DEPTH'(1);
        logic [KEY_WIDTH-1:0] neighbor;

        assign before_vec[i] = |(match_vec & LOW_MASK);

        if (i == DEPTH - 1) begin : g_last
            assign neighbor = '0;
        end else begin : g_mid
            assign neighbor = cell_value[i+1];
        end

        always_comb begin
            cell_ctl[i].cmp   = (state_reg == S_CMP);
            cell_ctl[i].live  = (COUNT_W'(i) < count_reg);
            cell_ctl[i].load  = 1'b0;
            cell_ctl[i].shift = 1'b0;
            if (exec_go) begin
                case (mode_reg)
                    OP_ENQ: begin
                        cell_ctl[i].load = !full && (count_reg == COUNT_W'(i));
                    end
                    OP_DEQ: begin
                        cell_ctl[i].shift = !empty;
                    end
                    OP_REMOVE: begin
                        cell_ctl[i].shift = match_vec[i] || before_vec[i];
                    end
                    default: begin
                        cell_ctl[i].shift = 1'b0;
                    end
                endcase
            end
        end

        fqrs_cell #(
            .KEY_WIDTH(KEY_WIDTH)
        ) u_cell (
            .aclk          (aclk),
            .ctl           (cell_ctl[i]),
            .key_in        (key_reg),
            .neighbor_value(neighbor),
            .value         (cell_value[i]),
            .match         (match_vec[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        head_next    = head_reg;
        found_next   = found_reg;
        status_next  = status_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = fqrs_op_t'(s_tuser);
                    key_next   = KEY_WIDTH'(s_tdata[KW_IN-1:0]);
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    m_valid_next = 1'b1;
                    head_next    = '0;
                    found_next   = 1'b0;
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                    case (mode_reg)
                        OP_ENQ: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                head_next = KEY_FIELD_W'(cell_value[0][KW_IN-1:0]);
                                if (mode_reg == OP_DEQ) begin
                                    count_next = count_reg - COUNT_W'(1);
                                end
                            end
                        end
                        OP_REMOVE, OP_SEARCH: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else if (any_match) begin
                                found_next = 1'b1;
                                if (mode_reg == OP_REMOVE) begin
                                    count_next = count_reg - COUNT_W'(1);
                                end
                            end else begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        head_reg   <= head_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign count_wide = 32'(count_reg);
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {count_wide[COUNT_FIELD_W-1:0], status_reg, found_reg, head_reg};

    `FQRS_ASSERT_IMP(a_count_range, 1'b1, count_reg <= COUNT_W'(DEPTH))
    `FQRS_ASSERT_IMP(a_full_means_full, m_valid_reg && (status_reg == ST_FULL), full)
    `FQRS_ASSERT_IMP(a_found_is_ok, m_valid_reg && found_reg, status_reg == ST_OK)
    `FQRS_ASSERT_NEXT(a_accept_to_cmp, s_tvalid && s_tready, state_reg == S_CMP)

endmodule
